[rtl/icr_pkg.sv]
// ----------------------------------------------------------------------------
// icr_pkg
// shared types and constants for the icmp reply classifier
// ----------------------------------------------------------------------------
package icr_pkg;

  localparam int unsigned MAX_DATAGRAM_BYTES = 65535;
  localparam int unsigned POS_W = 16;

  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // reply kind codes on the result port
  localparam logic [1:0] KIND_TIME_EXCEEDED = 2'd0;
  localparam logic [1:0] KIND_ECHO_REPLY    = 2'd1;
  localparam logic [1:0] KIND_OTHER         = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_EXPECTED_SEQUENCE   = 2'd0;
  localparam logic [1:0] REG_EXPECTED_IDENTIFIER = 2'd1;

  // front-end verdict: which id/seq word is to be checked, if any
  typedef enum logic [1:0] {
    CLS_TIME_EXCEEDED,
    CLS_ECHO_REPLY,
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [31:0] id_seq;
    logic [31:0] src;
  } rec_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

endpackage

[rtl/icr_front.sv]
// ----------------------------------------------------------------------------
// icr_front
// byte parser: tracks position, captures fields, classifies at the last byte
// ----------------------------------------------------------------------------
module icr_front import icr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] packet_byte,
  input  logic       last_byte,
  output logic       rec_push,
  output rec_t       rec
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [5:0]       outer_hdr_r, outer_hdr_nxt;
  logic [5:0]       inner_hdr_r, inner_hdr_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [31:0]      src_r, src_nxt;
  logic [31:0]      outer_word_r, outer_word_nxt;
  logic [31:0]      inner_word_r, inner_word_nxt;
  logic [3:0]       flags_r, flags_nxt;

  logic [POS_W-1:0] h16, q16;
  logic             active;

  assign active = (pos_r != POS_W'(MAX_DATAGRAM_BYTES));

  always_comb begin
    pos_nxt        = pos_r;
    outer_hdr_nxt  = outer_hdr_r;
    inner_hdr_nxt  = inner_hdr_r;
    type_nxt       = type_r;
    src_nxt        = src_r;
    outer_word_nxt = outer_word_r;
    inner_word_nxt = inner_word_r;
    flags_nxt      = flags_r;
    h16            = '0;
    q16            = '0;
    if (active) begin
      if (pos_r == '0) begin
        outer_hdr_nxt = {packet_byte[3:0], 2'b00};
      end
      h16 = {{(POS_W-6){1'b0}}, outer_hdr_nxt};
      if (pos_r >= POS_W'(12) && pos_r <= POS_W'(15)) begin
        src_nxt = {src_r[23:0], packet_byte};
        if (pos_r == POS_W'(15)) begin
          flags_nxt[0] = 1'b1;
        end
      end
      if (pos_r == h16) begin
        type_nxt     = packet_byte;
        flags_nxt[1] = 1'b1;
      end
      // headers are word multiples, so the byte lane is the low position bits
      if (pos_r >= h16 + POS_W'(4) && pos_r <= h16 + POS_W'(7)) begin
        outer_word_nxt[pos_r[1:0]*8 +: 8] = packet_byte;
        if (pos_r == h16 + POS_W'(7)) begin
          flags_nxt[2] = 1'b1;
        end
      end
      if (pos_r == h16 + POS_W'(8)) begin
        inner_hdr_nxt = {packet_byte[3:0], 2'b00};
      end
      q16 = h16 + POS_W'(8) + {{(POS_W-6){1'b0}}, inner_hdr_nxt};
      if (pos_r >= q16 + POS_W'(4) && pos_r <= q16 + POS_W'(7)) begin
        inner_word_nxt[pos_r[1:0]*8 +: 8] = packet_byte;
        if (pos_r == q16 + POS_W'(7)) begin
          flags_nxt[3] = 1'b1;
        end
      end
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  // verdict from the state as it stands after this byte
  always_comb begin
    rec.cls    = CLS_OTHER;
    rec.id_seq = outer_word_nxt;
    rec.src    = src_nxt;
    if (flags_nxt[0] && flags_nxt[1]) begin
      if (type_nxt == TYPE_TIME_EXCEEDED && flags_nxt[3]) begin
        rec.cls    = CLS_TIME_EXCEEDED;
        rec.id_seq = inner_word_nxt;
      end else if (type_nxt == TYPE_ECHO_REPLY && flags_nxt[2]) begin
        rec.cls = CLS_ECHO_REPLY;
      end
    end
  end

  assign rec_push = accept && last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n || rec_push) begin
      pos_r        <= '0;
      outer_hdr_r  <= '0;
      inner_hdr_r  <= '0;
      type_r       <= '0;
      src_r        <= '0;
      outer_word_r <= '0;
      inner_word_r <= '0;
      flags_r      <= '0;
    end else if (accept) begin
      pos_r        <= pos_nxt;
      outer_hdr_r  <= outer_hdr_nxt;
      inner_hdr_r  <= inner_hdr_nxt;
      type_r       <= type_nxt;
      src_r        <= src_nxt;
      outer_word_r <= outer_word_nxt;
      inner_word_r <= inner_word_nxt;
      flags_r      <= flags_nxt;
    end
  end

endmodule

[rtl/icr_queue.sv]
// ----------------------------------------------------------------------------
// icr_queue
// small queue of verdict records between front and back
// ----------------------------------------------------------------------------
module icr_queue import icr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  output logic full,
  input  logic pop,
  output logic empty,
  output rec_t pop_rec
);

  rec_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;
  logic                do_push, do_pop;

  assign full    = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_rec = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

[rtl/icr_back.sv]
// ----------------------------------------------------------------------------
// icr_back
// match registers, id/seq compare and result register
// ----------------------------------------------------------------------------
module icr_back import icr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_wr_t     cfg_wr,
  input  logic        q_empty,
  input  rec_t        q_rec,
  output logic        q_pop,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [1:0]  out_reply_kind,
  output logic [31:0] out_source_address
);

  logic [15:0] exp_seq_r, exp_id_r;
  logic        valid_r;
  logic [1:0]  kind_r, kind_nxt;
  logic [31:0] src_r, src_nxt;
  logic        match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_seq_r <= 16'd1;
      exp_id_r  <= 16'd0;
    end else if (cfg_wr.valid) begin
      if (cfg_wr.index == REG_EXPECTED_SEQUENCE) begin
        exp_seq_r <= cfg_wr.data;
      end else if (cfg_wr.index == REG_EXPECTED_IDENTIFIER) begin
        exp_id_r <= cfg_wr.data;
      end
    end
  end

  // low half identifier, high half sequence, both raw little-endian pairs
  assign match = (q_rec.id_seq[15:0] == exp_id_r) && (q_rec.id_seq[31:16] == exp_seq_r);

  always_comb begin
    kind_nxt = KIND_OTHER;
    unique case (q_rec.cls)
      CLS_TIME_EXCEEDED: if (match) kind_nxt = KIND_TIME_EXCEEDED;
      CLS_ECHO_REPLY:    if (match) kind_nxt = KIND_ECHO_REPLY;
      CLS_OTHER:         kind_nxt = KIND_OTHER;
      default:           kind_nxt = KIND_OTHER;
    endcase
    src_nxt = (kind_nxt == KIND_OTHER) ? 32'd0 : q_rec.src;
  end

  assign q_pop = !q_empty && (!valid_r || out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= kind_nxt;
      src_r  <= src_nxt;
    end
  end

  assign out_empty          = !valid_r;
  assign out_reply_kind     = kind_r;
  assign out_source_address = src_r;

endmodule

[rtl/icmp_reply_classifier_unit.sv]
// a result goes from the edge that accepts its last byte through the verdict queue into the result register
// throughput: one datagram byte per cycle while the verdict queue has room, set by the single-pass front parser
// the 4-deep verdict queue and the result register let both sides stall apart
// reset (rst_n low, synchronous): parser state, verdict queue and result register clear,
// expected_sequence returns to 1 and expected_identifier to 0
// ----------------------------------------------------------------------------
// icmp_reply_classifier_unit
// matches received icmp replies (time exceeded / echo reply) to a probe
// ----------------------------------------------------------------------------
module icmp_reply_classifier_unit import icr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input beats: one datagram byte each
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_last_byte,
  // result beats: one per datagram
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_reply_kind,
  output logic [31:0] out_source_address,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic    in_accept;
  logic    rec_push;
  rec_t    rec_in, rec_out;
  logic    q_full, q_empty, q_pop;
  cfg_wr_t cfg_wr;

  // a byte is taken whenever the verdict queue has room; only last bytes push
  assign in_accept = in_push && !in_full;
  assign in_full   = q_full;

  // registers are always writable; writes to unknown indexes are dropped
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // front: position tracking, field capture, per-datagram verdict
  icr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .packet_byte (in_packet_byte),
    .last_byte   (in_last_byte),
    .rec_push    (rec_push),
    .rec         (rec_in)
  );

  // decoupling queue
  icr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_rec (rec_in),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_rec  (rec_out)
  );

  // back: compare against expected id/seq, drive the result register
  icr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr             (cfg_wr),
    .q_empty            (q_empty),
    .q_rec              (rec_out),
    .q_pop              (q_pop),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_reply_kind     (out_reply_kind),
    .out_source_address (out_source_address)
  );

endmodule

[rtl/icr_checker.sv]
// ----------------------------------------------------------------------------
// icr_checker
// port-level assertions for the icmp reply classifier
// ----------------------------------------------------------------------------
module icr_checker import icr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [1:0]  out_reply_kind,
  input logic [31:0] out_source_address
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending right after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full right after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_reply_kind == KIND_TIME_EXCEEDED ||
                    out_reply_kind == KIND_ECHO_REPLY ||
                    out_reply_kind == KIND_OTHER))
    else $error("illegal reply kind");

  a_other_no_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_reply_kind == KIND_OTHER) |-> out_source_address == 32'd0)
    else $error("source address on an unmatched reply");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_reply_kind) && $stable(out_source_address)))
    else $error("stalled result changed");

endmodule

bind icmp_reply_classifier_unit icr_checker u_icr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_full            (in_full),
  .out_empty          (out_empty),
  .out_pop            (out_pop),
  .out_reply_kind     (out_reply_kind),
  .out_source_address (out_source_address)
);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks icmp_reply_classifier_unit: datagram bytes are pushed in, every
// datagram's verdict is predicted byte by byte and compared with the popped
// result; directed cases come first, then random replies under idling phases
// ----------------------------------------------------------------------------
module testbench;
  import icr_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 10;   // quiet time after the last expected result has popped
  localparam int WATCHDOG_LIMIT = 2000; // cycles in a row with no beat on any channel
  localparam int PHASE_BYTES    = 60;
  localparam int PHASE_REPLIES  = 2;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] src;
  } reply_t;

  // dut ports; the inputs driven here are known from time zero
  logic        clk;
  logic        rst_n              = 1'b0;
  logic        in_push            = 1'b0;
  logic        in_full;
  logic [7:0]  in_packet_byte     = 8'h00;
  logic        in_last_byte       = 1'b0;
  logic        out_empty;
  logic        out_pop            = 1'b0;
  logic [1:0]  out_reply_kind;
  logic [31:0] out_source_address;
  logic        cfg_valid          = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index          = REG_EXPECTED_SEQUENCE;
  logic [15:0] cfg_data           = 16'h0000;

  icmp_reply_classifier_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_packet_byte     (in_packet_byte),
    .in_last_byte       (in_last_byte),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_reply_kind     (out_reply_kind),
    .out_source_address (out_source_address),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor state: a private copy of the classifier
  // ---------------------------------------------------------------------------
  logic [15:0] match_seq = 16'd1;    // register copies, updated on write beats
  logic [15:0] match_id  = 16'd0;

  int          dg_pos;               // position of the next byte in the datagram
  int          outer_hlen;           // outer ihl * 4
  int          inner_hlen;           // quoted ihl * 4
  logic [7:0]  msg_type;
  logic [31:0] src_acc;
  logic [31:0] outer_word;           // echo id/seq, first byte in bits 7:0
  logic [31:0] inner_word;           // quoted id/seq
  logic [3:0]  seen;                 // source, type, outer word, inner word complete

  reply_t      pending_replies[$];   // verdicts still to come out of the dut

  // values the stimulus aims its matching replies at
  logic [15:0] probe_seq = 16'd1;
  logic [15:0] probe_id  = 16'd0;

  int          send_idle_pct = 0;
  int          pop_stall_pct = 0;
  int          idle_run      = 0;
  int          err_count     = 0;

  function automatic void clear_datagram();
    dg_pos     = 0;
    outer_hlen = 0;
    inner_hlen = 0;
    msg_type   = 8'h00;
    src_acc    = 32'h0;
    outer_word = 32'h0;
    inner_word = 32'h0;
    seen       = 4'b0000;
  endfunction

  function automatic bit word_matches(logic [31:0] w);
    return w[15:0] == match_id && w[31:16] == match_seq;
  endfunction

  // walks one accepted byte through the parser; queues a verdict on the last one
  function automatic void classify_byte(logic [7:0] b, logic last);
    int     p;
    int     h;
    int     q;
    reply_t r;
    p = dg_pos;
    if (p < MAX_DATAGRAM_BYTES) begin
      if (p == 0) outer_hlen = int'(b[3:0]) * 4;
      h = outer_hlen;
      // fields may overlap when ihl is small, so every test runs on every byte
      if (p >= 12 && p <= 15) begin
        src_acc = {src_acc[23:0], b};
        if (p == 15) seen[0] = 1'b1;
      end
      if (p == h) begin
        msg_type = b;
        seen[1]  = 1'b1;
      end
      if (p >= h + 4 && p <= h + 7) begin
        outer_word[(p - h - 4) * 8 +: 8] = b;
        if (p == h + 7) seen[2] = 1'b1;
      end
      if (p == h + 8) inner_hlen = int'(b[3:0]) * 4;
      q = h + 8 + inner_hlen;
      if (p >= q + 4 && p <= q + 7) begin
        inner_word[(p - q - 4) * 8 +: 8] = b;
        if (p == q + 7) seen[3] = 1'b1;
      end
      dg_pos = p + 1;
    end
    // bytes past the size limit are dropped but the last mark still counts
    if (last) begin
      r.kind = KIND_OTHER;
      if (seen[0] && seen[1]) begin
        if (msg_type == TYPE_TIME_EXCEEDED) begin
          if (seen[3] && word_matches(inner_word)) r.kind = KIND_TIME_EXCEEDED;
        end else if (msg_type == TYPE_ECHO_REPLY) begin
          if (seen[2] && word_matches(outer_word)) r.kind = KIND_ECHO_REPLY;
        end
      end
      r.src = (r.kind == KIND_OTHER) ? 32'h0 : src_acc;
      pending_replies.push_back(r);
      clear_datagram();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: every beat on every channel, sampled at the clock edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    reply_t exp_r;
    bit     moved;
    moved = 1'b0;
    if (rst_n) begin
      // register writes are to land only while the datapath is quiet; the dut does not enforce this
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        if (cfg_index == REG_EXPECTED_SEQUENCE) match_seq = cfg_data;
        else if (cfg_index == REG_EXPECTED_IDENTIFIER) match_id = cfg_data;
      end
      // input beat first, so a verdict is queued before any result could pop
      if (in_push && !in_full) begin
        moved = 1'b1;
        classify_byte(in_packet_byte, in_last_byte);
      end
      if (out_pop && !out_empty) begin
        moved = 1'b1;
        if (pending_replies.size() == 0) begin
          $display("%0t: result with nothing expected: kind %0d source %h",
                   $time, out_reply_kind, out_source_address);
          err_count++;
        end else begin
          exp_r = pending_replies.pop_front();
          if (out_reply_kind !== exp_r.kind) begin
            $display("%0t: reply kind expected %0d, got %0d",
                     $time, exp_r.kind, out_reply_kind);
            err_count++;
          end
          if (out_source_address !== exp_r.src) begin
            $display("%0t: source address expected %h, got %h",
                     $time, exp_r.src, out_source_address);
            err_count++;
          end
        end
      end
    end
    idle_run = moved ? 0 : idle_run + 1;
  end

  // receiver: pop low on a random share of cycles
  always @(posedge clk) begin
    out_pop <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  // watchdog: the run is stuck if no beat moves for too long
  initial begin
    while (idle_run < WATCHDOG_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one input beat; returns at the edge that takes it
  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_packet_byte <= b;
    in_last_byte   <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // sends the first total_len bytes of hdr, padding with random bytes past its end
  task automatic send_datagram(input byte_q_t hdr, input int total_len);
    logic [7:0] b;
    for (int i = 0; i < total_len; i++) begin
      b = (i < hdr.size()) ? hdr[i] : 8'($urandom_range(0, 255));
      send_byte(b, i == total_len - 1);
    end
  endtask

  // stop pushing, wait for every verdict, then let the pipeline run dry
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers back to back; valid stays high across the two beats
  task automatic write_regs(input logic [15:0] seq, input logic [15:0] id);
    cfg_valid <= 1'b1;
    cfg_index <= REG_EXPECTED_SEQUENCE;
    cfg_data  <= seq;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_EXPECTED_IDENTIFIER;
    cfg_data  <= id;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    probe_seq  = seq;
    probe_id   = id;
  endtask

  // full-length reply with every field placed; the echo word is written last
  function automatic byte_q_t build_reply(input logic [7:0] ityp, input int ihl,
                                          input int inner_ihl, input logic [31:0] src,
                                          input logic [15:0] id, input logic [15:0] seq);
    byte_q_t d;
    int      h;
    int      q;
    int      n;
    h = ihl * 4;
    q = h + 8 + inner_ihl * 4;
    n = (q + 8 > 16) ? q + 8 : 16;
    for (int i = 0; i < n; i++) d.push_back(8'($urandom_range(0, 255)));
    d[0] = {4'h4, 4'(ihl)};
    for (int i = 0; i < 4; i++) d[12 + i] = src[31 - 8 * i -: 8];
    d[h + 8] = {4'h4, 4'(inner_ihl)};
    d[q + 4] = id[7:0];
    d[q + 5] = id[15:8];
    d[q + 6] = seq[7:0];
    d[q + 7] = seq[15:8];
    d[h]     = ityp;
    d[h + 4] = id[7:0];
    d[h + 5] = id[15:8];
    d[h + 6] = seq[7:0];
    d[h + 7] = seq[15:8];
    return d;
  endfunction

  // reply sent in full plus a few trailing payload bytes
  task automatic send_reply(input logic [7:0] ityp, input int ihl, input int inner_ihl,
                            input logic [31:0] src, input logic [15:0] id,
                            input logic [15:0] seq);
    byte_q_t d;
    d = build_reply(ityp, ihl, inner_ihl, src, id, seq);
    send_datagram(d, d.size() + $urandom_range(0, 6));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers at their reset values: sequence 1, identifier 0
  task automatic test_reset_defaults();
    send_reply(TYPE_ECHO_REPLY, 5, 5, 32'hc0a80001, probe_id, probe_seq);
    send_reply(TYPE_TIME_EXCEEDED, 5, 5, 32'h0a000001, probe_id, probe_seq);
    settle();
  endtask

  // match and near-miss for both reply types, plus an unrelated type
  task automatic test_matching_replies();
    write_regs(16'h0007, 16'h1234);
    send_reply(TYPE_ECHO_REPLY, 5, 5, 32'hffffffff, probe_id, probe_seq);
    send_reply(TYPE_TIME_EXCEEDED, 5, 5, 32'h00000000, probe_id, probe_seq);
    send_reply(TYPE_TIME_EXCEEDED, 5, 5, 32'h01020304, probe_id, probe_seq ^ 16'h0100);
    send_reply(TYPE_ECHO_REPLY, 5, 5, 32'h05060708, probe_id ^ 16'h0001, probe_seq);
    // byte-swapped pair must not match
    send_reply(TYPE_ECHO_REPLY, 5, 5, 32'h0a0b0c0d, 16'h3412, probe_seq);
    // destination unreachable carries a good quote but is still other
    send_reply(8'd3, 5, 5, 32'h7f000001, probe_id, probe_seq);
    settle();
  endtask

  // datagrams that end before a needed field is complete, and one that is just long enough
  task automatic test_short_datagrams();
    byte_q_t d;
    send_datagram(d, 1);                    // last mark on the very first byte
    d = build_reply(TYPE_ECHO_REPLY, 5, 5, 32'h11223344, probe_id, probe_seq);
    send_datagram(d, 14);                   // source cut off
    send_datagram(d, 20);                   // type missing
    send_datagram(d, 27);                   // echo word one byte short
    send_datagram(d, 28);                   // just long enough
    d = build_reply(TYPE_TIME_EXCEEDED, 5, 5, 32'h55667788, probe_id, probe_seq);
    send_datagram(d, 47);                   // quoted word cut off
    send_datagram(d, 48);
    settle();
  endtask

  // ihl at its extremes, including zero where the fields overlap
  task automatic test_header_lengths();
    send_reply(TYPE_ECHO_REPLY, 0, 5, 32'h9abcdef0, probe_id, probe_seq);
    send_reply(TYPE_TIME_EXCEEDED, 5, 0, 32'h13579bdf, probe_id, probe_seq);
    send_reply(TYPE_TIME_EXCEEDED, 15, 15, 32'h2468ace0, probe_id, probe_seq);
    send_reply(TYPE_ECHO_REPLY, 15, 5, 32'hfedcba98, probe_id, probe_seq);
    send_reply(TYPE_ECHO_REPLY, 1, 5, 32'h0f0f0f0f, probe_id, probe_seq);
    send_reply(TYPE_TIME_EXCEEDED, 2, 1, 32'hf0f0f0f0, probe_id, probe_seq);
    settle();
  endtask

  // registers at all ones, then all zeros
  task automatic test_register_extremes();
    write_regs(16'hffff, 16'hffff);
    send_reply(TYPE_ECHO_REPLY, 5, 5, 32'h80000001, probe_id, probe_seq);
    send_reply(TYPE_TIME_EXCEEDED, 6, 7, 32'h00000080, probe_id, probe_seq);
    send_reply(TYPE_ECHO_REPLY, 5, 5, 32'h12345678, 16'hfffe, probe_seq);
    settle();
    write_regs(16'h0000, 16'h0000);
    send_reply(TYPE_ECHO_REPLY, 5, 5, 32'h87654321, probe_id, probe_seq);
    send_reply(TYPE_TIME_EXCEEDED, 5, 5, 32'haaaaaaaa, probe_id, probe_seq);
    send_reply(TYPE_TIME_EXCEEDED, 5, 5, 32'h55555555, probe_id, 16'h8000);
    settle();
  endtask

  // mostly well-formed replies with random fields, some cut short, some noise
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    byte_q_t     d;
    int          sel;
    int          ihl;
    int          inner_ihl;
    int          len;
    int          sent_bytes;
    int          sent_dgrams;
    logic [7:0]  ityp;
    logic [15:0] id;
    logic [15:0] seq;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    sent_bytes  = 0;
    sent_dgrams = 0;
    while (sent_bytes < PHASE_BYTES || sent_dgrams < PHASE_REPLIES) begin
      sel       = $urandom_range(0, 9);
      ihl       = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
      inner_ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
      id        = probe_id;
      seq       = probe_seq;
      // one reply in four misses by a single bit
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0) id  = id  ^ (16'h1 << $urandom_range(0, 15));
        else                           seq = seq ^ (16'h1 << $urandom_range(0, 15));
      end
      if (sel <= 3)      ityp = TYPE_ECHO_REPLY;
      else if (sel <= 7) ityp = TYPE_TIME_EXCEEDED;
      else               ityp = 8'($urandom_range(0, 255));
      d   = build_reply(ityp, ihl, inner_ihl, 32'($urandom), id, seq);
      len = d.size() + $urandom_range(0, 10);
      if ($urandom_range(0, 6) == 0) len = $urandom_range(1, d.size());
      if (sel == 9) begin
        // pure noise
        d.delete();
        len = $urandom_range(1, 48);
      end
      send_datagram(d, len);
      sent_bytes  += len;
      sent_dgrams += 1;
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    clear_datagram();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_matching_replies();
    test_short_datagrams();
    test_header_lengths();
    test_register_extremes();

    test_random_traffic(0, 0);
    test_random_traffic(57, 0);
    test_random_traffic(0, 57);
    test_random_traffic(29, 29);

    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
